// ===== rtl/core/mcti_pkg.sv =====
// Package for the swept circle time of impact pipeline: widths, constants, sideband type.
package mcti_pkg;

	localparam int unsigned IN_W       = 232;
	localparam int unsigned OUT_W      = 24;
	localparam int unsigned A_W        = 42;
	localparam int unsigned H_W        = 47;
	localparam int unsigned D_W        = 92;
	localparam int unsigned SQ_W       = 94;
	localparam int unsigned SQ_STEPS   = 47;
	localparam int unsigned DIV_STEPS  = 18;
	localparam int unsigned REM_W      = 64;
	localparam logic [16:0] ONE_FRAME  = 17'd65536;
	localparam logic [15:0] EPS_RESET  = 16'd1;

	// Values carried alongside the root and quotient chains.
	typedef struct packed {
		logic [A_W-1:0] a;
		logic [H_W-1:0] h;
		logic [16:0]    cur;
		logic           fail;
	} side_t;

endpackage

// ===== rtl/core/moving_circle_time_of_impact.sv =====
// Swept circle-circle time of impact, fully pipelined.
//
// s_tdata carries one circle pair per transaction; m_tdata returns one result for
// every accepted pair, in order. Configuration: the user writes discriminant epsilon
// through cfg_we/cfg_wdata while the pipeline is empty; the block does not enforce it.
//
// Throughput: one pair per cycle unless m_tready stalls the pipeline. The
// path from input to output register runs through the 47-stage square root
// (one result bit per stage) and the 18-stage restoring divider (one quotient
// bit per stage), plus seven stages for differences, products and the
// discriminant, one for the numerator and the output register.
//
// All stages share one enable: when m_tvalid is high and m_tready low the
// whole pipeline holds, and s_tready drops in the same cycle, so nothing is
// lost or repeated. Reset clears every valid bit and sets epsilon to 1.
module moving_circle_time_of_impact (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [15:0]                cfg_wdata,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// pos_a_x, pos_a_y, pos_b_x, pos_b_y, vel_a_x, vel_a_y, vel_b_x, vel_b_y,
	// radius_a, radius_b, cur_time, zero fill
	input  logic [mcti_pkg::IN_W-1:0]  s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// hit, hit_time, zero fill
	output logic [mcti_pkg::OUT_W-1:0] m_tdata
);
	import mcti_pkg::*;

	logic        en;
	logic [15:0] eps_q;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
		end else if (cfg_we) begin
			eps_q <= cfg_wdata;
		end
	end

	// ---------------- S1: differences
	logic signed [24:0] dpx_s1, dpy_s1;
	logic signed [20:0] dvx_s1, dvy_s1;
	logic [16:0]        len_s1, cur_s1;
	logic               v_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dpx_s1 <= 25'($signed(s_tdata[23:0])) - 25'($signed(s_tdata[71:48]));
			dpy_s1 <= 25'($signed(s_tdata[47:24])) - 25'($signed(s_tdata[95:72]));
			dvx_s1 <= 21'($signed(s_tdata[115:96])) - 21'($signed(s_tdata[155:136]));
			dvy_s1 <= 21'($signed(s_tdata[135:116])) - 21'($signed(s_tdata[175:156]));
			len_s1 <= {1'b0, s_tdata[191:176]} + {1'b0, s_tdata[207:192]};
			cur_s1 <= s_tdata[224:208];
		end
	end

	// ---------------- S2: products
	logic signed [41:0] dvx_e, dvy_e;
	logic signed [45:0] dpx_h, dpy_h, dvx_h, dvy_h;
	logic signed [49:0] dpx_e, dpy_e;
	logic [33:0]        len_e;
	logic signed [41:0] vxx_s2, vyy_s2;
	logic signed [45:0] pxv_s2, pyv_s2;
	logic signed [49:0] pxx_s2, pyy_s2;
	logic [33:0]        ll_s2;
	logic [16:0]        cur_s2;
	logic               v_s2;

	assign dvx_e = 42'(dvx_s1);
	assign dvy_e = 42'(dvy_s1);
	assign dpx_h = 46'(dpx_s1);
	assign dpy_h = 46'(dpy_s1);
	assign dvx_h = 46'(dvx_s1);
	assign dvy_h = 46'(dvy_s1);
	assign dpx_e = 50'(dpx_s1);
	assign dpy_e = 50'(dpy_s1);
	assign len_e = 34'(len_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			vxx_s2 <= dvx_e * dvx_e;
			vyy_s2 <= dvy_e * dvy_e;
			pxv_s2 <= dpx_h * dvx_h;
			pyv_s2 <= dpy_h * dvy_h;
			pxx_s2 <= dpx_e * dpx_e;
			pyy_s2 <= dpy_e * dpy_e;
			ll_s2  <= len_e * len_e;
			cur_s2 <= cur_s1;
		end
	end

	// ---------------- S3: a, h, c
	logic [A_W-1:0]     a_s3;
	logic signed [46:0] h_s3;
	logic signed [50:0] c_s3;
	logic [16:0]        cur_s3;
	logic               v_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3   <= A_W'(vxx_s2[40:0]) + A_W'(vyy_s2[40:0]);
			h_s3   <= 47'(pxv_s2) + 47'(pyv_s2);
			c_s3   <= 51'(pxx_s2) + 51'(pyy_s2) - $signed({17'd0, ll_s2});
			cur_s3 <= cur_s2;
		end
	end

	// ---------------- S4: partial products of h*h and a*|c|
	logic [46:0] habs;
	logic [50:0] cabs;
	logic [45:0] hh_c, hl_c, ah_c, al_c, ch_c, cl_c;
	logic [45:0] hhh_s4, hhl_s4, hll_s4, ahch_s4, ahcl_s4, alch_s4, alcl_s4;
	logic [A_W-1:0] a_s4;
	logic [H_W-1:0] h_s4;
	logic           cneg_s4, azero_s4;
	logic [16:0]    cur_s4;
	logic           v_s4;

	assign habs = h_s3[46] ? 47'(-h_s3) : 47'(h_s3);
	assign cabs = c_s3[50] ? 51'(-c_s3) : 51'(c_s3);
	assign hh_c = 46'(habs[45:23]);
	assign hl_c = 46'(habs[22:0]);
	assign ah_c = 46'(a_s3[41:21]);
	assign al_c = 46'(a_s3[20:0]);
	assign ch_c = 46'(cabs[49:25]);
	assign cl_c = 46'(cabs[24:0]);

	always_ff @(posedge clk) begin
		if (en) begin
			hhh_s4   <= hh_c * hh_c;
			hhl_s4   <= hh_c * hl_c;
			hll_s4   <= hl_c * hl_c;
			ahch_s4  <= ah_c * ch_c;
			ahcl_s4  <= ah_c * cl_c;
			alch_s4  <= al_c * ch_c;
			alcl_s4  <= al_c * cl_c;
			a_s4     <= a_s3;
			h_s4     <= h_s3;
			cneg_s4  <= c_s3[50];
			azero_s4 <= (a_s3 == '0);
			cur_s4   <= cur_s3;
		end
	end

	// ---------------- S5: p = h*h, q = a*|c|
	logic [D_W-1:0] p_s5, q_s5;
	logic [A_W-1:0] a_s5;
	logic [H_W-1:0] h_s5;
	logic           cneg_s5, azero_s5;
	logic [16:0]    cur_s5;
	logic           v_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s5 <= (D_W'(hhh_s4) << 46) + (D_W'(hhl_s4) << 24) + D_W'(hll_s4);
			// a splits at bit 21, |c| at bit 25
			q_s5 <= (D_W'(ahch_s4) << 46) + (D_W'(ahcl_s4) << 21)
				+ (D_W'(alch_s4) << 25) + D_W'(alcl_s4);
			a_s5     <= a_s4;
			h_s5     <= h_s4;
			cneg_s5  <= cneg_s4;
			azero_s5 <= azero_s4;
			cur_s5   <= cur_s4;
		end
	end

	// ---------------- S6: reduced discriminant
	logic [D_W-1:0] d_s6;
	side_t          sd_s6;
	logic           v_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			d_s6        <= cneg_s5 ? p_s5 + q_s5 : p_s5 - q_s5;
			sd_s6.a     <= a_s5;
			sd_s6.h     <= h_s5;
			sd_s6.cur   <= cur_s5;
			sd_s6.fail  <= azero_s5 || (!cneg_s5 && (p_s5 < q_s5));
		end
	end

	// ---------------- S7: epsilon test, root chain entry (index 0)
	logic [SQ_W-1:0] sq_x_s [0:SQ_STEPS];
	logic [SQ_W-1:0] sq_r_s [0:SQ_STEPS];
	side_t           sq_sd_s [0:SQ_STEPS];
	logic            sq_v_s [0:SQ_STEPS];
	logic            small_c;
	side_t           sq_sd_c;

	// 4*D below epsilon; epsilon is 16 bits so only tiny D qualify
	assign small_c = (d_s6[D_W-1:14] == '0) && ({d_s6[13:0], 2'b00} < eps_q);

	always_comb begin
		sq_sd_c      = sd_s6;
		sq_sd_c.fail = sd_s6.fail || small_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_x_s[0]  <= SQ_W'(d_s6);
			sq_r_s[0]  <= '0;
			sq_sd_s[0] <= sq_sd_c;
		end
	end

	genvar k;
	generate
		for (k = 0; k < SQ_STEPS; k++) begin : g_sqrt
			localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (92 - 2 * k);
			logic [SQ_W-1:0] trial;
			logic            take;
			assign trial = sq_r_s[k] + BIT;
			assign take  = sq_x_s[k] >= trial;
			always_ff @(posedge clk) begin
				if (en) begin
					sq_x_s[k+1]  <= take ? sq_x_s[k] - trial : sq_x_s[k];
					sq_r_s[k+1]  <= take ? (sq_r_s[k] >> 1) + BIT : sq_r_s[k] >> 1;
					sq_sd_s[k+1] <= sq_sd_s[k];
				end
			end
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					sq_v_s[k+1] <= 1'b0;
				end else if (en) begin
					sq_v_s[k+1] <= sq_v_s[k];
				end
			end
		end
	endgenerate

	// ---------------- S8: numerator n = -h - s, range checks, divider entry
	logic [REM_W-1:0] dv_rem_s [0:DIV_STEPS];
	logic [17:0]      dv_q_s [0:DIV_STEPS];
	side_t            dv_sd_s [0:DIV_STEPS];
	logic             dv_v_s [0:DIV_STEPS];
	logic signed [48:0] n_c;
	logic [48:0]        a4_c;
	side_t              dv_sd_c;

	assign n_c  = -49'($signed(sq_sd_s[SQ_STEPS].h))
		- $signed({2'b00, sq_r_s[SQ_STEPS][46:0]});
	assign a4_c = {5'd0, sq_sd_s[SQ_STEPS].a, 2'b00};

	// negative root, or quotient of 2^18 or more (surely past the frame)
	always_comb begin
		dv_sd_c      = sq_sd_s[SQ_STEPS];
		dv_sd_c.fail = sq_sd_s[SQ_STEPS].fail || n_c[48] || (49'(n_c) >= a4_c);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_rem_s[0] <= {n_c[47:0], 16'd0};
			dv_q_s[0]   <= '0;
			dv_sd_s[0]  <= dv_sd_c;
		end
	end

	genvar j;
	generate
		for (j = 0; j < DIV_STEPS; j++) begin : g_div
			logic [REM_W-1:0] sub;
			logic             take;
			assign sub  = REM_W'(dv_sd_s[j].a) << (DIV_STEPS - 1 - j);
			assign take = dv_rem_s[j] >= sub;
			always_ff @(posedge clk) begin
				if (en) begin
					dv_rem_s[j+1] <= take ? dv_rem_s[j] - sub : dv_rem_s[j];
					dv_q_s[j+1]   <= {dv_q_s[j][16:0], take};
					dv_sd_s[j+1]  <= dv_sd_s[j];
				end
			end
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					dv_v_s[j+1] <= 1'b0;
				end else if (en) begin
					dv_v_s[j+1] <= dv_v_s[j];
				end
			end
		end
	endgenerate

	// ---------------- output register
	logic [18:0] sum_c;
	logic        hit_c;
	logic        hit_q;
	logic [16:0] time_q;

	assign sum_c = 19'(dv_q_s[DIV_STEPS]) + 19'(dv_sd_s[DIV_STEPS].cur);
	assign hit_c = !dv_sd_s[DIV_STEPS].fail && (dv_sd_s[DIV_STEPS].cur <= ONE_FRAME)
		&& (sum_c <= 19'(ONE_FRAME));

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q  <= hit_c;
			time_q <= hit_c ? sum_c[16:0] : 17'd0;
		end
	end

	assign m_tdata = {6'd0, time_q, hit_q};

	// valid bits of the front stages and output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			sq_v_s[0] <= 1'b0;
			dv_v_s[0] <= 1'b0;
			m_tvalid  <= 1'b0;
		end else if (en) begin
			v_s1      <= s_tvalid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			v_s5      <= v_s4;
			v_s6      <= v_s5;
			sq_v_s[0] <= v_s6;
			dv_v_s[0] <= sq_v_s[SQ_STEPS];
			m_tvalid  <= dv_v_s[DIV_STEPS];
		end
	end

endmodule
